@@ hdl/ffa_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffa_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam int AW = 20;  // payload offset width
    localparam int SW = 21;  // size / counter width

    localparam logic [SW-1:0] HEAP_LIMIT = 21'h100000;
    localparam logic [SW-1:0] COUNT_MAX  = 21'h1FFFFF;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_FREED     = 3'd2,
        ST_NULL      = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic init;
        logic take;
        logic rd_head;
        logic rd_succ;
        logic ld_cur;
        logic alloc_whole;
        logic fail;
        logic pop_rd;
        logic split_new;
        logic split_cur;
        logic null_req;
        logic free_mark;
        logic unknown;
        logic merge;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic fit;
        logic split;
        logic last;
        logic is_null;
        logic match;
        logic merge_ok;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hdl/ffa_in_if.sv @@
// Request channel of the allocator: valid/ready plus request item.
// Depends on ffa_pkg.
interface ffa_in_if import ffa_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          mode;
    logic [SW-1:0] request_size;
    logic [AW-1:0] payload_address;

    modport source (output valid, mode, request_size, payload_address, input ready);
    modport sink   (input valid, mode, request_size, payload_address, output ready);
endinterface

@@ hdl/ffa_out_if.sv @@
// Response channel of the allocator: valid/ready plus result item.
// Depends on ffa_pkg.
interface ffa_out_if import ffa_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [AW-1:0] result_address;
    logic [2:0]    status;
    logic [SW-1:0] free_bytes;

    modport source (output valid, result_address, status, free_bytes, input ready);
    modport sink   (input valid, result_address, status, free_bytes, output ready);
endinterface

@@ hdl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with split and coalesce.
// Depends on ffa_pkg, ffa_in_if, ffa_out_if, ffa_ctrl, ffa_dp, ffa_ram.
//
// Usage:
//  - i_req (valid/ready) carries one request item: mode 0 allocates
//    request_size payload bytes, mode 1 frees payload_address.
//  - o_rsp (valid/ready) returns one item per request: result_address,
//    status and the free-byte counter after that request.
//  - i_cfg_we/i_cfg_data write heap_size (saturated into range) and
//    rebuild the table as a single free block; write only while idle.
// Timing: one request at a time. Allocate walks the list to the first
// fitting block, plus S_ASPLIT and S_AMARK when it splits, or to the
// end when nothing fits. Free walks the list to find the block, then
// walks all listed blocks to coalesce; null frees skip both walks. The
// walks are set by the single read port of the block table, one list
// step a cycle. Reset (synchronous, active low) and a configuration
// write rewrite entry 0 in S_INIT; i_req.ready stays low meanwhile. No
// clearing pass: spare table indices come from a high-water mark and a
// stack. A stalled o_rsp holds its item; the next request is taken and
// worked on, and waits in S_DONE until the output register frees.
module first_fit_heap_allocator import ffa_pkg::*; #(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [SW-1:0] i_cfg_data,
    ffa_in_if.sink        i_req,
    ffa_out_if.source     o_rsp
);
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_req.ready = in_ready;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ffa_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_req.mode),
        .i_size       (i_req.request_size),
        .i_addr       (i_req.payload_address),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_res_addr   (o_rsp.result_address),
        .o_res_status (o_rsp.status),
        .o_free_bytes (o_rsp.free_bytes)
    );
endmodule

@@ hdl/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/ffa_ctrl.sv @@
// Sequencer of the allocator: walks the block list, splits, frees, coalesces.
// Depends on ffa_pkg; drives ffa_dp through t_dp_cmd.
module ffa_ctrl import ffa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_cfg_we,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_ready
);
    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_ALOOK  = 10'b0000000100,
        S_ASPLIT = 10'b0000001000,
        S_AMARK  = 10'b0000010000,
        S_FLOOK  = 10'b0000100000,
        S_CHEAD  = 10'b0001000000,
        S_CLOAD  = 10'b0010000000,
        S_CCHK   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.take    = 1'b1;
                    o_cmd.rd_head = 1'b1;
                    n_state       = i_sts.mode ? S_FLOOK : S_ALOOK;
                end
            end
            S_ALOOK: begin
                if (i_sts.fit) begin
                    if (i_sts.split) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_ASPLIT;
                    end else begin
                        o_cmd.alloc_whole = 1'b1;
                        n_state           = S_DONE;
                    end
                end else if (i_sts.last) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.rd_succ = 1'b1;
                end
            end
            S_ASPLIT: begin
                o_cmd.split_new = 1'b1;
                n_state         = S_AMARK;
            end
            S_AMARK: begin
                o_cmd.split_cur = 1'b1;
                n_state         = S_DONE;
            end
            S_FLOOK: begin
                if (i_sts.is_null) begin
                    o_cmd.null_req = 1'b1;
                    n_state        = S_DONE;
                end else if (i_sts.match) begin
                    o_cmd.free_mark = 1'b1;
                    n_state         = S_CHEAD;
                end else if (i_sts.last) begin
                    o_cmd.unknown = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rd_succ = 1'b1;
                end
            end
            S_CHEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_CLOAD;
            end
            S_CLOAD: begin
                o_cmd.ld_cur = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_succ = 1'b1;
                    n_state       = S_CCHK;
                end
            end
            S_CCHK: begin
                if (i_sts.merge_ok) begin
                    o_cmd.merge = 1'b1;
                end else begin
                    o_cmd.ld_cur = 1'b1;
                end
                if (i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_succ = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end
endmodule

@@ hdl/ffa_dp.sv @@
// Datapath of the allocator: block table, spare-index stack, counter, result register.
// Depends on ffa_pkg and ffa_ram; commanded by ffa_ctrl.
module ffa_dp import ffa_pkg::*; #(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic          i_cfg_we,
    input  logic [SW-1:0] i_cfg_data,
    input  logic          i_mode,
    input  logic [SW-1:0] i_size,
    input  logic [AW-1:0] i_addr,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [AW-1:0] o_res_addr,
    output logic [2:0]    o_res_status,
    output logic [SW-1:0] o_free_bytes
);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int TW = 2 * AW + 1 + IW;
    localparam logic [SW:0]   HDR22 = (SW + 1)'(HEADER_BYTES);
    localparam logic [SW-1:0] HDR21 = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);

    // configuration and request
    logic [SW-1:0] r_heap;
    logic          r_mode;
    logic [SW-1:0] r_size;
    logic [AW-1:0] r_addr;

    // block table
    logic          tw_we, t_re;
    logic [IW-1:0] tw_addr, t_raddr;
    logic [TW-1:0] tw_data, t_rdata;
    logic [IW-1:0] r_rd_idx;

    logic [AW-1:0] rd_start, rd_len;
    logic          rd_free;
    logic [IW-1:0] rd_succ;

    // current block of the coalescing pass
    logic [IW-1:0] r_cur_idx;
    logic [AW-1:0] r_cur_start, r_cur_len;
    logic          r_cur_free;

    // spare indices: stack of returned ones plus a high-water mark
    logic          s_we;
    logic [IW-1:0] s_rdata;
    logic [CW-1:0] r_sp, r_hwm;
    logic [IW-1:0] new_idx, r_new_idx;
    logic          idx_avail;

    logic [SW-1:0] r_cnt;
    logic [AW-1:0] r_res_addr;
    t_status       r_res_status;

    logic [SW-1:0] cfg_sat;
    logic [SW:0]   need, cnt_sum, len_hdr;
    logic [AW-1:0] merged_len;

    assign rd_start = t_rdata[TW-1 -: AW];
    assign rd_len   = t_rdata[TW-AW-1 -: AW];
    assign rd_free  = t_rdata[IW];
    assign rd_succ  = t_rdata[IW-1:0];

    assign need       = {1'b0, r_size} + HDR22;
    assign len_hdr    = {2'b0, rd_len} + HDR22;
    assign cnt_sum    = {1'b0, r_cnt} + len_hdr;
    assign merged_len = AW'(r_cur_len + len_hdr[AW-1:0]);
    assign idx_avail  = (r_sp != '0) || (r_hwm != MAXC);
    assign new_idx    = (r_sp != '0) ? s_rdata : r_hwm[IW-1:0];

    always_comb begin
        cfg_sat = i_cfg_data;
        if (i_cfg_data < HDR21 + SW'(1)) begin
            cfg_sat = HDR21 + SW'(1);
        end else if (i_cfg_data > HEAP_LIMIT) begin
            cfg_sat = HEAP_LIMIT;
        end
    end

    assign o_sts.mode     = i_mode;
    assign o_sts.fit      = rd_free && ({1'b0, rd_len} >= r_size);
    assign o_sts.split    = ({2'b0, rd_len} > need) && idx_avail;
    assign o_sts.last     = (rd_succ == '0);
    assign o_sts.is_null  = (r_addr == '0);
    assign o_sts.match    = ({1'b0, rd_start} + HDR21) == {1'b0, r_addr};
    assign o_sts.merge_ok = r_cur_free && rd_free;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // table write and read port selection
    always_comb begin
        tw_we   = 1'b0;
        tw_addr = r_rd_idx;
        tw_data = {rd_start, rd_len, 1'b0, rd_succ};
        if (i_cmd.init) begin
            tw_we   = 1'b1;
            tw_addr = '0;
            tw_data = {{AW{1'b0}}, AW'(r_heap - HDR21), 1'b1, {IW{1'b0}}};
        end else if (i_cmd.alloc_whole) begin
            tw_we = 1'b1;
        end else if (i_cmd.split_new) begin
            tw_we   = 1'b1;
            tw_addr = new_idx;
            tw_data = {AW'(need[AW-1:0] + rd_start), AW'(rd_len - need[AW-1:0]),
                       1'b1, rd_succ};
        end else if (i_cmd.split_cur) begin
            tw_we   = 1'b1;
            tw_data = {rd_start, r_size[AW-1:0], 1'b0, r_new_idx};
        end else if (i_cmd.free_mark) begin
            tw_we   = 1'b1;
            tw_data = {rd_start, rd_len, 1'b1, rd_succ};
        end else if (i_cmd.merge) begin
            tw_we   = 1'b1;
            tw_addr = r_cur_idx;
            tw_data = {r_cur_start, merged_len, 1'b1, rd_succ};
        end
    end

    assign t_re    = i_cmd.rd_head || i_cmd.rd_succ;
    assign t_raddr = i_cmd.rd_head ? '0 : rd_succ;
    assign s_we    = i_cmd.merge;

    ffa_ram #(.WIDTH(TW), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (tw_we),
        .i_waddr (tw_addr),
        .i_wdata (tw_data),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    ffa_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_spare (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_sp[IW-1:0]),
        .i_wdata (r_rd_idx),
        .i_re    (i_cmd.pop_rd),
        .i_raddr (IW'(r_sp - CW'(1))),
        .o_rdata (s_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap      <= HEAP_LIMIT;
            r_sp        <= '0;
            r_hwm       <= CW'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap <= cfg_sat;
            end
            if (i_cmd.init) begin
                r_sp  <= '0;
                r_hwm <= CW'(1);
            end else if (i_cmd.split_new) begin
                if (r_sp != '0) begin
                    r_sp <= r_sp - CW'(1);
                end else begin
                    r_hwm <= r_hwm + CW'(1);
                end
            end else if (i_cmd.merge) begin
                r_sp <= r_sp + CW'(1);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_cnt <= r_heap - HDR21;
        end else if (i_cmd.alloc_whole || i_cmd.split_cur) begin
            r_cnt <= ({1'b0, r_cnt} > need) ? SW'({1'b0, r_cnt} - need) : '0;
        end else if (i_cmd.free_mark) begin
            r_cnt <= (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[SW-1:0];
        end
        if (i_cmd.take) begin
            r_mode <= i_mode;
            r_size <= i_size;
            r_addr <= i_addr;
        end
        if (t_re) begin
            r_rd_idx <= t_raddr;
        end
        if (i_cmd.split_new) begin
            r_new_idx <= new_idx;
        end
        if (i_cmd.ld_cur) begin
            r_cur_idx   <= r_rd_idx;
            r_cur_start <= rd_start;
            r_cur_len   <= rd_len;
            r_cur_free  <= rd_free;
        end else if (i_cmd.merge) begin
            r_cur_len <= merged_len;
        end
        if (i_cmd.take) begin
            r_res_addr   <= '0;
            r_res_status <= i_mode ? ST_FREED : ST_NO_FIT;
        end else if (i_cmd.alloc_whole || i_cmd.split_cur) begin
            r_res_addr   <= AW'(rd_start + HDR21[AW-1:0]);
            r_res_status <= ST_ALLOCATED;
        end else if (i_cmd.null_req) begin
            r_res_status <= ST_NULL;
        end else if (i_cmd.unknown) begin
            r_res_status <= ST_UNKNOWN;
        end else if (i_cmd.fail) begin
            r_res_status <= ST_NO_FIT;
        end else if (i_cmd.free_mark) begin
            r_res_status <= r_mode ? ST_FREED : ST_NO_FIT;
        end
        if (i_cmd.out_load) begin
            o_res_addr   <= r_res_addr;
            o_res_status <= r_res_status;
            o_free_bytes <= r_cnt;
        end
    end

`ifndef SYNTHESIS
    a_hwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hwm <= MAXC) else $error("high-water mark beyond table");
    a_sp_below_hwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp < r_hwm) else $error("more spare indices than issued");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten while stalled");
    a_split_has_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_rd |=> idx_avail) else $error("split without spare index");
`endif
endmodule
